/* sv/cansd_pkg.sv */
`timescale 1ns / 1ps

package cansd_pkg;

  localparam int unsigned DataWidth  = 64;
  localparam int unsigned LenWidth   = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_START_BIT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MOTOROLA    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCALE       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CKSUM_BYTE  = 3'd6;

  localparam logic [63:0] PhysMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PhysMin = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] frame_data;
    logic [3:0]  frame_bytes;
  } in_word_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic signed [63:0] physical_value;
    logic               saturated;
    logic [7:0]         xor_checksum;
  } res_t;

  typedef struct packed {
    logic [5:0]         signal_start_bit;
    logic [6:0]         signal_length;
    logic               motorola_order;
    logic               signed_signal;
    logic signed [31:0] scale_factor;
    logic signed [47:0] offset_value;
    logic [2:0]         excl_byte;
  } cfg_t;

  // Lengths above 64 behave as 64.
  function automatic logic [LenWidth-1:0] clamp_len(input logic [LenWidth-1:0] len);
    return len[6] ? 7'd64 : len;
  endfunction

  // Ones in the low n bits, n from 0 to 64.
  function automatic logic [DataWidth-1:0] low_mask(input logic [LenWidth-1:0] n);
    return n[6] ? {DataWidth{1'b1}} : ((64'd1 << n[5:0]) - 64'd1);
  endfunction

endpackage

/* sv/cansd_cfg.sv */
`timescale 1ns / 1ps

module cansd_cfg import cansd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                cfg_ready_o,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Registers are plain flops, so a write always completes at once.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_BIT:  cfg_d.signal_start_bit = cfg_data_i[5:0];
        CFG_LENGTH:     cfg_d.signal_length    = cfg_data_i[6:0];
        CFG_MOTOROLA:   cfg_d.motorola_order   = cfg_data_i[0];
        CFG_SIGNED:     cfg_d.signed_signal    = cfg_data_i[0];
        CFG_SCALE:      cfg_d.scale_factor     = signed'(cfg_data_i[31:0]);
        CFG_OFFSET:     cfg_d.offset_value     = signed'(cfg_data_i[47:0]);
        CFG_CKSUM_BYTE: cfg_d.excl_byte        = cfg_data_i[2:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signal_start_bit <= 6'd0;
      cfg_q.signal_length    <= 7'd8;
      cfg_q.motorola_order   <= 1'b0;
      cfg_q.signed_signal    <= 1'b0;
      cfg_q.scale_factor     <= 32'sd65536;
      cfg_q.offset_value     <= 48'sd0;
      cfg_q.excl_byte        <= 3'd7;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/cansd_extract.sv */
`timescale 1ns / 1ps

module cansd_extract import cansd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  in_word_t    in_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output logic [63:0] raw_o,
  output logic [7:0]  xor_o
);

  logic [3:0]  nbytes;
  logic [6:0]  len_c;
  logic [63:0] mdata, rdata, shift_d;
  logic [5:0]  moto_pos;
  logic [6:0]  avail, moto_left, cnt_d;
  logic [7:0]  xor_d;

  // Stage A: drop bytes past the frame end, line the signal up at bit 0,
  // count how many bits will be read, and XOR the frame bytes other than the excluded one.
  always_comb begin
    nbytes = (in_i.frame_bytes > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : in_i.frame_bytes;
    len_c  = clamp_len(cfg_i.signal_length);
    xor_d  = 8'd0;
    for (int i = 0; i < 8; i++) begin
      mdata[8*i +: 8] = (4'(i) < nbytes) ? in_i.frame_data[8*i +: 8] : 8'd0;
      if ((4'(i) < nbytes) && (3'(i) != cfg_i.excl_byte)) begin
        xor_d = xor_d ^ in_i.frame_data[8*i +: 8];
      end
      // Motorola order reads each byte from bit 7 down, so reverse the bits
      // within each byte and the walk becomes a plain rising index.
      for (int b = 0; b < 8; b++) begin
        rdata[8*i + b] = mdata[8*i + 7 - b];
      end
    end
    moto_pos  = {cfg_i.signal_start_bit[5:3], ~cfg_i.signal_start_bit[2:0]};
    avail     = {nbytes, 3'b000};
    moto_left = (avail > {1'b0, moto_pos}) ? (avail - {1'b0, moto_pos}) : 7'd0;
    if (cfg_i.motorola_order) begin
      shift_d = rdata >> moto_pos;
      cnt_d   = (moto_left < len_c) ? moto_left : len_c;
    end else begin
      shift_d = mdata >> cfg_i.signal_start_bit;
      cnt_d   = len_c;
    end
  end

  logic        a_valid_q;
  logic [63:0] a_shift_q;
  logic [6:0]  a_cnt_q;
  logic [7:0]  a_xor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_shift_q <= shift_d;
    a_cnt_q   <= cnt_d;
    a_xor_q   <= xor_d;
  end

  // Stage B: keep the counted bits; Motorola bits arrive MSB first, so they
  // are reversed and brought back down to bit 0.
  logic [63:0] kept, kept_rev, raw_d;

  always_comb begin
    kept = a_shift_q & low_mask(a_cnt_q);
    for (int j = 0; j < 64; j++) begin
      kept_rev[j] = kept[63 - j];
    end
    raw_d = cfg_i.motorola_order ? (kept_rev >> (7'd64 - a_cnt_q)) : kept;
  end

  logic        b_valid_q;
  logic [63:0] b_raw_q;
  logic [7:0]  b_xor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_raw_q <= raw_d;
    b_xor_q <= a_xor_q;
  end

  assign valid_o = b_valid_q;
  assign raw_o   = b_raw_q;
  assign xor_o   = b_xor_q;

endmodule

/* sv/cansd_scale.sv */
`timescale 1ns / 1ps

module cansd_scale import cansd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] raw_i,
  input  logic [7:0]  xor_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output res_t        res_o
);

  // Stage C: sign and magnitude of the raw value and of the scale.
  logic [6:0]  len_c;
  logic [5:0]  sign_idx;
  logic        sign_ext;
  logic [63:0] sval, mag_d;
  logic        vneg;
  logic [31:0] scale_u, smag_d;

  always_comb begin
    len_c    = clamp_len(cfg_i.signal_length);
    sign_idx = len_c[5:0] - 6'd1;
    sign_ext = cfg_i.signed_signal && (len_c != 7'd0) && !len_c[6] && raw_i[sign_idx];
    sval     = sign_ext ? (raw_i | ~low_mask(len_c)) : raw_i;
    vneg     = cfg_i.signed_signal && sval[63];
    mag_d    = vneg ? (64'd0 - sval) : sval;
    scale_u  = unsigned'(cfg_i.scale_factor);
    smag_d   = scale_u[31] ? (~scale_u + 32'd1) : scale_u;
  end

  logic        c_valid_q, d_valid_q, e_valid_q, f_valid_q;
  logic [63:0] c_mag_q;
  logic [31:0] c_smag_q;
  logic        c_neg_q, d_neg_q, e_neg_q;
  logic [63:0] c_raw_q, d_raw_q, e_raw_q;
  logic [7:0]  c_xor_q, d_xor_q, e_xor_q;
  logic [63:0] d_p0_q, d_p1_q;
  logic [95:0] e_prod_q;
  res_t        f_res_q;

  // Stage D: two 32 x 32 partial products.
  logic [63:0] p0_d, p1_d;
  assign p0_d = c_mag_q[31:0] * c_smag_q;
  assign p1_d = c_mag_q[63:32] * c_smag_q;

  // Stage E: exact 96-bit magnitude product.
  logic [95:0] prod_d;
  assign prod_d = {32'd0, d_p0_q} + {d_p1_q, 32'd0};

  // Stage F: apply the sign as invert plus carry-in, add the offset and clip.
  logic [97:0] prod_x, sum;
  logic [34:0] top_bits;
  logic        fits;
  res_t        res_d;

  always_comb begin
    prod_x   = e_neg_q ? ~{2'b00, e_prod_q} : {2'b00, e_prod_q};
    sum      = prod_x + {{50{cfg_i.offset_value[47]}}, cfg_i.offset_value}
               + {97'd0, e_neg_q};
    top_bits = sum[97:63];
    fits     = (&top_bits) || !(|top_bits);
    res_d.raw_value      = e_raw_q;
    res_d.xor_checksum   = e_xor_q;
    res_d.saturated      = !fits;
    res_d.physical_value = fits ? signed'(sum[63:0])
                                : (sum[97] ? signed'(PhysMin) : signed'(PhysMax));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      c_valid_q <= valid_i;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_mag_q  <= mag_d;
    c_smag_q <= smag_d;
    c_neg_q  <= vneg ^ scale_u[31];
    c_raw_q  <= raw_i;
    c_xor_q  <= xor_i;

    d_p0_q   <= p0_d;
    d_p1_q   <= p1_d;
    d_neg_q  <= c_neg_q;
    d_raw_q  <= c_raw_q;
    d_xor_q  <= c_xor_q;

    e_prod_q <= prod_d;
    e_neg_q  <= d_neg_q;
    e_raw_q  <= d_raw_q;
    e_xor_q  <= d_xor_q;

    f_res_q  <= res_d;
  end

  assign valid_o = f_valid_q;
  assign res_o   = f_res_q;

endmodule

/* sv/can_signal_decoder.sv */
`timescale 1ns / 1ps
// An accepted frame passes through registered stages A to F before its result word appears.
// Throughput: one frame per cycle; busy stays low, since every stage takes a new
// frame each cycle and the slowest stage is one 32 x 32 multiply or one 98-bit add.
// Results are strobed for one cycle on res_valid_o; the receiver cannot stall.
// Reset clears the stage valid bits and loads the register defaults.

module can_signal_decoder import cansd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_word_t            in_word_i,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t        cfg;
  logic        ext_valid;
  logic [63:0] ext_raw;
  logic [7:0]  ext_xor;

  assign busy = 1'b0;

  cansd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  cansd_extract #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .in_i    (in_word_i),
    .cfg_i   (cfg),
    .valid_o (ext_valid),
    .raw_o   (ext_raw),
    .xor_o   (ext_xor)
  );

  cansd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ext_valid),
    .raw_i   (ext_raw),
    .xor_i   (ext_xor),
    .cfg_i   (cfg),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule

/* sv/cansd_checker.sv */
`timescale 1ns / 1ps

module cansd_checker import cansd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input in_word_t in_word_i,
  input logic     res_valid_o,
  input res_t     res_o
);

  // Every accepted frame yields a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 res_valid_o)
    else $error("accepted frame gave no result word");

  // No word appears without an accepted frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##6 !res_valid_o)
    else $error("result word without a frame");

  // A clipped value sits at one end of the signed range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.saturated) |->
      (res_o.physical_value == signed'(PhysMax) ||
       res_o.physical_value == signed'(PhysMin)))
    else $error("saturated value not at a range limit");

  // An empty frame reads no bits and no bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.frame_bytes == 4'd0) |->
      ##6 (res_o.raw_value == 64'd0 && res_o.xor_checksum == 8'd0))
    else $error("empty frame gave nonzero raw value or checksum");

endmodule

bind can_signal_decoder cansd_checker u_cansd_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cansd_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  in_word_t            in_word_i;
  logic                res_valid_o;
  res_t                res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  can_signal_decoder #(.FRAME_BYTES(8)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cfg_t sig_cfg;
  res_t pending_results[$];
  int   err_count = 0;
  bit   gaps_on = 1'b1;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Expected result of one frame under the current register settings.
  function automatic res_t decode_frame(input in_word_t w);
    res_t r;
    int unsigned nb, len, pos, byte_i, bit_i;
    logic [63:0] raw, ext;
    logic signed [127:0] val, scl, off, total;
    logic [7:0] x;
    nb = (w.frame_bytes > 8) ? 8 : w.frame_bytes;
    len = (sig_cfg.signal_length > 64) ? 64 : sig_cfg.signal_length;
    raw = '0;
    if (!sig_cfg.motorola_order) begin
      for (int i = 0; i < len; i++) begin
        pos = sig_cfg.signal_start_bit + i;
        // Bits past the last valid byte stay zero.
        if (pos / 8 < nb) raw[i] = w.frame_data[pos];
      end
    end else begin
      byte_i = sig_cfg.signal_start_bit / 8;
      bit_i = sig_cfg.signal_start_bit % 8;
      for (int i = 0; i < len; i++) begin
        // Once past the frame end, no further bits are shifted in.
        if (byte_i < nb) begin
          raw = {raw[62:0], w.frame_data[byte_i * 8 + bit_i]};
          if (bit_i == 0) begin
            bit_i = 7;
            byte_i++;
          end else begin
            bit_i--;
          end
        end
      end
    end
    ext = raw;
    if (sig_cfg.signed_signal && len >= 1 && len <= 63 && raw[len-1]) ext = raw | (~64'd0 << len);
    if (sig_cfg.signed_signal) val = $signed({{64{ext[63]}}, ext});
    else val = $signed({64'd0, raw});
    scl = $signed({{96{sig_cfg.scale_factor[31]}}, sig_cfg.scale_factor});
    off = $signed({{80{sig_cfg.offset_value[47]}}, sig_cfg.offset_value});
    total = val * scl + off;
    r.raw_value = raw;
    if (total[127:63] == '0 || total[127:63] == '1) begin
      r.physical_value = total[63:0];
      r.saturated = 1'b0;
    end else begin
      r.physical_value = total[127] ? PhysMin : PhysMax;
      r.saturated = 1'b1;
    end
    x = '0;
    for (int i = 0; i < nb; i++) begin
      if (i != sig_cfg.excl_byte) x ^= w.frame_data[i*8 +: 8];
    end
    r.xor_checksum = x;
    return r;
  endfunction

  function automatic in_word_t rand_frame();
    in_word_t w;
    w.frame_data = {$urandom(), $urandom()};
    if ($urandom_range(0, 9) == 0) w.frame_bytes = 4'($urandom_range(9, 15));
    else w.frame_bytes = 4'($urandom_range(0, 8));
    return w;
  endfunction

  // Called just after a rising edge; returns just after the edge that took the word.
  task automatic send_frame(input in_word_t w);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      in_word_i <= rand_frame();
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(decode_frame(w));
  endtask

  task automatic send_data(input logic [63:0] data, input logic [3:0] nbytes);
    in_word_t w;
    w.frame_data = data;
    w.frame_bytes = nbytes;
    send_frame(w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Upper data bits above a register's width are filled with noise.
  // The write valid is left high so writes can follow back to back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'({$urandom(), $urandom()});
    case (idx)
      CFG_START_BIT: begin
        d[5:0] = val[5:0];
        sig_cfg.signal_start_bit = val[5:0];
      end
      CFG_LENGTH: begin
        d[6:0] = val[6:0];
        sig_cfg.signal_length = val[6:0];
      end
      CFG_MOTOROLA: begin
        d[0] = val[0];
        sig_cfg.motorola_order = val[0];
      end
      CFG_SIGNED: begin
        d[0] = val[0];
        sig_cfg.signed_signal = val[0];
      end
      CFG_SCALE: begin
        d[31:0] = val[31:0];
        sig_cfg.scale_factor = val[31:0];
      end
      CFG_OFFSET: begin
        d = val;
        sig_cfg.offset_value = val;
      end
      CFG_CKSUM_BYTE: begin
        d[2:0] = val[2:0];
        sig_cfg.excl_byte = val[2:0];
      end
      default: ;
    endcase
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [5:0] sbit, input logic [6:0] len, input logic moto,
                            input logic sgn, input logic [31:0] scale,
                            input logic [47:0] offset, input logic [2:0] cksum);
    write_reg(CFG_START_BIT, 48'(sbit));
    write_reg(CFG_LENGTH, 48'(len));
    write_reg(CFG_MOTOROLA, 48'(moto));
    write_reg(CFG_SIGNED, 48'(sgn));
    write_reg(CFG_SCALE, 48'(scale));
    write_reg(CFG_OFFSET, offset);
    write_reg(CFG_CKSUM_BYTE, 48'(cksum));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_data(64'h0123_4567_89AB_CDEF, 4'd8);
    send_data(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_data(64'hFEDC_BA98_7654_3210, 4'd15);
    send_data(64'h1122_3344_5566_7788, 4'd3);
    wait_idle();
  endtask

  task automatic test_intel_order();
    // Length above 64 acts as 64, read as signed.
    set_config(6'd0, 7'd127, 1'b0, 1'b1, 32'h0001_0000, 48'd0, 3'd0);
    send_data(64'h8000_0000_0000_0001, 4'd8);
    wait_idle();
    set_config(6'd12, 7'd12, 1'b0, 1'b1, 32'hFFFF_0000, 48'h0000_0001_8000, 3'd5);
    send_data(64'h0000_0000_00F8_0000, 4'd8);
    send_data(64'h0000_0000_00F8_0000, 4'd1);
    send_data(64'h0000_0000_0FF8_0000, 4'd2);
    wait_idle();
    set_config(6'd63, 7'd0, 1'b0, 1'b1, 32'h7FFF_FFFF, 48'h8000_0000_0000, 3'd7);
    send_data(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    wait_idle();
  endtask

  task automatic test_motorola_order();
    set_config(6'd7, 7'd64, 1'b1, 1'b0, 32'h0000_0001, 48'd0, 3'd0);
    send_data(64'h0123_4567_89AB_CDEF, 4'd8);
    send_data(64'h0123_4567_89AB_CDEF, 4'd4);
    wait_idle();
    // Signal wraps from bit 0 of one byte to bit 7 of the next.
    set_config(6'd3, 7'd12, 1'b1, 1'b1, 32'h0002_8000, 48'hFFFF_FFFF_0000, 3'd2);
    send_data(64'h0000_0000_0000_FF0F, 4'd2);
    send_data(64'h0000_0000_0000_FF0F, 4'd1);
    send_data(64'h0000_0000_0000_7F07, 4'd2);
    wait_idle();
    set_config(6'd63, 7'd9, 1'b1, 1'b0, 32'h0001_0000, 48'd0, 3'd7);
    send_data(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    wait_idle();
  endtask

  task automatic test_saturation();
    set_config(6'd0, 7'd64, 1'b0, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 3'd3);
    send_data(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_data(64'h0000_0000_0000_FFFF, 4'd8);
    wait_idle();
    set_config(6'd0, 7'd64, 1'b0, 1'b1, 32'h8000_0000, 48'h8000_0000_0000, 3'd6);
    send_data(64'h8000_0000_0000_0000, 4'd8);
    send_data(64'h7FFF_FFFF_FFFF_FFFF, 4'd8);
    send_data(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    wait_idle();
  endtask

  task automatic test_random_frames();
    logic [6:0]  len;
    logic [31:0] scale;
    logic [47:0] offset;
    for (int ph = 0; ph < 17; ph++) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
        1, 2: len = 7'd64;
        default: len = 7'($urandom_range(1, 63));
      endcase
      case ($urandom_range(0, 5))
        0: scale = 32'h8000_0000;
        1: scale = 32'h7FFF_FFFF;
        2, 3: scale = $urandom_range(0, 1) ? $urandom_range(0, 200000)
                                           : -$urandom_range(0, 200000);
        default: scale = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0: offset = 48'h7FFF_FFFF_FFFF;
        1: offset = 48'h8000_0000_0000;
        default: offset = 48'({$urandom(), $urandom()});
      endcase
      if (ph == 0) begin
        set_config(6'd63, 7'd64, 1'b1, 1'b1, 32'h8000_0000, 48'h8000_0000_0000, 3'd0);
      end else if (ph == 1) begin
        set_config(6'd0, 7'd64, 1'b0, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 3'd7);
      end else begin
        set_config(6'($urandom_range(0, 63)), len, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), scale, offset, 3'($urandom_range(0, 7)));
      end
      gaps_on = (ph < 14);
      repeat (50) send_frame(rand_frame());
      wait_idle();
    end
  endtask

  // Each result word is checked against the oldest expected one.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        flag_error("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (res_o.raw_value !== want.raw_value)
          flag_error($sformatf("raw_value %h, expected %h", res_o.raw_value, want.raw_value));
        if (res_o.physical_value !== want.physical_value)
          flag_error($sformatf("physical_value %h, expected %h",
                               res_o.physical_value, want.physical_value));
        if (res_o.saturated !== want.saturated)
          flag_error($sformatf("saturated %b, expected %b", res_o.saturated, want.saturated));
        if (res_o.xor_checksum !== want.xor_checksum)
          flag_error($sformatf("xor_checksum %h, expected %h",
                               res_o.xor_checksum, want.xor_checksum));
      end
    end
  end

  initial begin
    sig_cfg.signal_start_bit = 6'd0;
    sig_cfg.signal_length = 7'd8;
    sig_cfg.motorola_order = 1'b0;
    sig_cfg.signed_signal = 1'b0;
    sig_cfg.scale_factor = 32'sd65536;
    sig_cfg.offset_value = '0;
    sig_cfg.excl_byte = 3'd7;
    rst_ni = 1'b0;
    start = 1'b0;
    in_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_intel_order();
    test_motorola_order();
    test_saturation();
    test_random_frames();
    repeat (12) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
